// File: rtl/swerve_wheel_kinematics_top_assert.svh
// Assertion macros shared by the swerve kinematics RTL
`ifndef SWERVE_WHEEL_KINEMATICS_TOP_ASSERT_SVH
`define SWERVE_WHEEL_KINEMATICS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, masked while rst_ni is low
`define SWK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swk: assertion failed");

// Next-cycle implication, sampled on clk_i, masked while rst_ni is low
`define SWK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swk: assertion failed");

`endif

// File: rtl/swk_pkg.sv
// Shared types, constants and tables for the swerve kinematics block
package swk_pkg;

  // Field widths
  localparam int VEL_W      = 16;
  localparam int COMP_W     = 18;
  localparam int TURN_W     = 15;
  localparam int SPEED_W    = 16;
  localparam int ANG_W      = 16;
  localparam int THR_W      = 15;
  localparam int SCALE_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EFFORT_THR  = 1'b0,
    REG_SPEED_SCALE = 1'b1
  } cfg_reg_e;

  localparam logic [THR_W-1:0]   THR_RESET   = 15'd410;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

  // CORDIC
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int STEP_W           = 5;
  localparam int CORD_W           = 28;
  localparam logic signed [CORD_W-1:0] HALF_PI_Q24 = 28'sd26353589;

  // Angle arithmetic in 18 bits, Q3.12
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

  // Rotation term and multiplier
  localparam logic signed [17:0] COS45_Q15 = 18'sd23170;
  localparam int MUL_W  = 18;
  localparam int PROD_W = 36;

  // Square root
  localparam int SUM_W     = 33;
  localparam int SQ_IN_W   = 50;
  localparam int SQ_ROOT_W = 25;
  localparam int SQ_REM_W  = 26;
  localparam int SQ_CNT_W  = 5;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] angle;
  } cordic_res_t;

  typedef struct packed {
    logic                 done;
    logic [SQ_ROOT_W-1:0] root;
  } sqrt_res_t;

  // atan(2^-i) in Q.24
  function automatic logic signed [CORD_W-1:0] atan_q24(input logic [STEP_W-1:0] i);
    logic signed [CORD_W-1:0] r;
    begin
      case (i)
        5'd0:    r = 28'sd13176795;
        5'd1:    r = 28'sd7778716;
        5'd2:    r = 28'sd4110060;
        5'd3:    r = 28'sd2086331;
        5'd4:    r = 28'sd1047214;
        5'd5:    r = 28'sd524117;
        5'd6:    r = 28'sd262123;
        5'd7:    r = 28'sd131069;
        5'd8:    r = 28'sd65536;
        5'd9:    r = 28'sd32768;
        5'd10:   r = 28'sd16384;
        5'd11:   r = 28'sd8192;
        5'd12:   r = 28'sd4096;
        5'd13:   r = 28'sd2048;
        5'd14:   r = 28'sd1024;
        5'd15:   r = 28'sd512;
        5'd16:   r = 28'sd256;
        5'd17:   r = 28'sd128;
        5'd18:   r = 28'sd64;
        5'd19:   r = 28'sd32;
        5'd20:   r = 28'sd16;
        5'd21:   r = 28'sd8;
        5'd22:   r = 28'sd4;
        5'd23:   r = 28'sd2;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: rtl/swk_ifs.sv
// Valid/ready channel interfaces for commands and wheel results
interface swk_in_if;
  import swk_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_turn;
  modport source (output valid, vel_x, vel_y, vel_turn, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_turn, output ready);
endinterface

interface swk_out_if;
  import swk_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TURN_W-1:0] turn_front_left;
  logic signed [TURN_W-1:0] turn_front_right;
  logic signed [TURN_W-1:0] turn_back_left;
  logic signed [TURN_W-1:0] turn_back_right;
  logic [SPEED_W-1:0]       speed_front_left;
  logic [SPEED_W-1:0]       speed_front_right;
  logic [SPEED_W-1:0]       speed_back_left;
  logic [SPEED_W-1:0]       speed_back_right;
  modport source (output valid, turn_front_left, turn_front_right, turn_back_left,
                  turn_back_right, speed_front_left, speed_front_right,
                  speed_back_left, speed_back_right, input ready);
  modport sink   (input valid, turn_front_left, turn_front_right, turn_back_left,
                  turn_back_right, speed_front_left, speed_front_right,
                  speed_back_left, speed_back_right, output ready);
endinterface

// File: rtl/swk_cordic.sv
// Iterative vectoring CORDIC: atan2 in Q3.12, one micro-rotation per cycle
module swk_cordic #(
  parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [swk_pkg::COMP_W-1:0]   y_i,
  input  logic signed [swk_pkg::COMP_W-1:0]   x_i,
  output swk_pkg::cordic_res_t                res_o
);
  import swk_pkg::*;

  localparam logic [STEP_W-1:0] LAST = STEP_W'(CORDIC_STEPS - 1);

  logic signed [CORD_W-1:0] x_q, y_q, z_q;
  logic signed [CORD_W-1:0] x_d, y_d, z_d;
  logic signed [CORD_W-1:0] xe, ye, dx, dy, zr;
  logic [STEP_W-1:0]        step_q;
  logic                     busy_q, done_q, zero_q;

  // Inputs scaled by 256 into the working width
  assign xe = {{(CORD_W-COMP_W-8){x_i[COMP_W-1]}}, x_i, 8'b0};
  assign ye = {{(CORD_W-COMP_W-8){y_i[COMP_W-1]}}, y_i, 8'b0};

  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;

  // Pre-rotation into the right half plane, or one micro-rotation
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (start_i) begin
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_d = ye;
          y_d = -xe;
          z_d = HALF_PI_Q24;
        end else begin
          x_d = -ye;
          y_d = xe;
          z_d = -HALF_PI_Q24;
        end
      end else begin
        x_d = xe;
        y_d = ye;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_q24(step_q);
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_q24(step_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  // Round Q.24 to Q.12
  assign zr          = z_q + 28'sd2048;
  assign res_o.done  = done_q;
  assign res_o.angle = zero_q ? '0 : zr[CORD_W-1:12];

endmodule

// File: rtl/swk_sqrt.sv
// Bit-serial integer square root of (sum << 16), one root bit per cycle
module swk_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [swk_pkg::SUM_W-1:0]      sum_i,
  output swk_pkg::sqrt_res_t             res_o
);
  import swk_pkg::*;

  localparam logic [SQ_CNT_W-1:0] LAST = SQ_CNT_W'(SQ_ROOT_W - 1);

  logic [SQ_IN_W-1:0]   n_q;
  logic [SQ_REM_W-1:0]  rem_q;
  logic [SQ_ROOT_W-1:0] root_q;
  logic [SQ_CNT_W-1:0]  cnt_q;
  logic                 busy_q, done_q;
  logic [SQ_REM_W+1:0]  rem_sh, trial;
  logic                 fits;

  // Next remainder digit and trial subtrahend
  assign rem_sh = {rem_q, n_q[SQ_IN_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= {1'b0, sum_i, 16'b0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= {n_q[SQ_IN_W-3:0], 2'b00};
      rem_q  <= fits ? SQ_REM_W'(rem_sh - trial) : SQ_REM_W'(rem_sh);
      root_q <= {root_q[SQ_ROOT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.root = root_q;

endmodule

// File: rtl/swerve_wheel_kinematics_top.sv
// Swerve drive inverse kinematics: four steering changes and wheel speeds per command
//
//  channel  dir  handshake         beat
//  in_ch    in   valid/ready       vel_x, vel_y, vel_turn
//  out_ch   out  valid/ready       four turn_*, four speed_*
//  cfg      in   cfg_we_i          cfg_idx_i, cfg_wdata_i
//
// A command passes from one accept to the next through idle, the rotation term and effort
// test, then per wheel the squares, the bit-serial square root (the CORDIC runs alongside
// it and ends first), scale and write-back, and finally the load of the output register.
// The square root is the longest step. in_ch is taken only while the sequencer idles; the
// result sits in an output register, so a new command is accepted while out_ch is stalled.
// Reset clears the stored wheel angles to zero and the registers to their defaults.
`include "swerve_wheel_kinematics_top_assert.svh"

module swerve_wheel_kinematics_top #(
  parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  swk_in_if.sink                            in_ch,
  swk_out_if.source                         out_ch,
  input  logic                              cfg_we_i,
  input  logic [swk_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [swk_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import swk_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PRE  = 7'b0000010,
    S_WSQ  = 7'b0000100,
    S_RUN  = 7'b0001000,
    S_SCL  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [THR_W-1:0]          thr_q;
  logic [SCALE_W-1:0]        scale_q;
  logic signed [VEL_W-1:0]   vx_q, vy_q, vw_q, p_q;
  logic [31:0]               eff_q;
  logic                      upd_q;
  logic signed [PROD_W-1:0]  prod_q, prod;
  logic signed [MUL_W-1:0]   ma, mb;
  logic [2:0]                cnt_q;
  logic [1:0]                wheel_q;
  logic [SUM_W-1:0]          sum_q, sq_sum;
  logic [40:0]               scl_q;
  logic                      cdone_q, sdone_q;
  logic signed [ANG_W-1:0]   angle_q [4];
  logic signed [TURN_W-1:0]  turn_q [4];
  logic [SPEED_W-1:0]        speed_q [4];
  logic signed [TURN_W-1:0]  oturn_q [4];
  logic [SPEED_W-1:0]        ospeed_q [4];
  logic                      ovalid_q;

  logic signed [COMP_W-1:0]  vxe, vye, pe, vxp, vxm, vyp, vym, ay, ax, sa;
  logic signed [PROD_W-1:0]  p_rnd;
  logic                      cordic_start, sqrt_start, run_done, out_load;
  cordic_res_t               cd_res;
  sqrt_res_t                 sq_res;
  logic [41:0]               spd_rnd;
  logic [17:0]               spd_raw;
  logic [SPEED_W-1:0]        spd_sat;
  logic signed [17:0]        tgt, diff, new_ang;

  function automatic logic signed [17:0] wrap_ang(input logic signed [17:0] a);
    logic signed [17:0] r;
    begin
      r = a;
      if (r >= PI_Q12) begin
        r = r - TWO_PI_Q12;
      end else if (r < -PI_Q12) begin
        r = r + TWO_PI_Q12;
      end
      return r;
    end
  endfunction

  // Wheel vector components
  assign vxe = {{2{vx_q[VEL_W-1]}}, vx_q};
  assign vye = {{2{vy_q[VEL_W-1]}}, vy_q};
  assign pe  = {{2{p_q[VEL_W-1]}}, p_q};
  assign vxp = vxe + pe;
  assign vxm = vxe - pe;
  assign vyp = vye + pe;
  assign vym = vye - pe;
  // Steering uses (vy -+ p) for front/back, speed pairs the y sign the other way
  assign ay  = wheel_q[1] ? vyp : vym;
  assign ax  = wheel_q[0] ? vxp : vxm;
  assign sa  = wheel_q[1] ? vym : vyp;

  // Shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == S_PRE) begin
      case (cnt_q)
        3'd0:    begin ma = {{2{vw_q[VEL_W-1]}}, vw_q}; mb = COS45_Q15; end
        3'd1:    begin ma = vxe; mb = vxe; end
        3'd2:    begin ma = vye; mb = vye; end
        3'd3:    begin ma = {{2{vw_q[VEL_W-1]}}, vw_q}; mb = {{2{vw_q[VEL_W-1]}}, vw_q}; end
        3'd4:    begin ma = {3'b0, thr_q}; mb = {3'b0, thr_q}; end
        default: ;
      endcase
    end else if (state_q == S_WSQ) begin
      case (cnt_q)
        3'd0:    begin ma = sa; mb = sa; end
        3'd1:    begin ma = ax; mb = ax; end
        default: ;
      endcase
    end
  end

  assign prod         = ma * mb;
  assign p_rnd        = prod_q + 36'sd16384;
  assign sq_sum       = sum_q + {1'b0, prod_q[31:0]};
  assign sqrt_start   = (state_q == S_WSQ) && (cnt_q == 3'd2);
  assign cordic_start = sqrt_start && upd_q;
  assign run_done     = (sdone_q || sq_res.done) && (cdone_q || cd_res.done || !upd_q);
  assign out_load     = (state_q == S_DONE) && (!ovalid_q || out_ch.ready);

  swk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .y_i     (ay),
    .x_i     (ax),
    .res_o   (cd_res)
  );

  swk_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .sum_i   (sq_sum),
    .res_o   (sq_res)
  );

  // Speed rounding and saturation
  assign spd_rnd = {1'b0, scl_q} + 42'h0000080_0000;
  assign spd_raw = spd_rnd[41:24];
  assign spd_sat = (|spd_raw[17:16]) ? '1 : spd_raw[15:0];

  // Steering change against the stored angle
  assign tgt     = -{{2{cd_res.angle[ANG_W-1]}}, cd_res.angle};
  assign diff    = wrap_ang(tgt - {{2{angle_q[wheel_q][ANG_W-1]}}, angle_q[wheel_q]});
  assign new_ang = wrap_ang({{2{angle_q[wheel_q][ANG_W-1]}}, angle_q[wheel_q]} + diff);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_ch.valid) state_d = S_PRE;
      S_PRE:  if (cnt_q == 3'd5) state_d = S_WSQ;
      S_WSQ:  if (cnt_q == 3'd2) state_d = S_RUN;
      S_RUN:  if (run_done) state_d = S_SCL;
      S_SCL:  state_d = S_FIN;
      S_FIN:  state_d = (wheel_q == 2'd3) ? S_DONE : S_WSQ;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      wheel_q  <= '0;
      cdone_q  <= 1'b0;
      sdone_q  <= 1'b0;
      ovalid_q <= 1'b0;
      thr_q    <= THR_RESET;
      scale_q  <= SCALE_RESET;
      for (int i = 0; i < 4; i++) begin
        angle_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else if (state_q == S_PRE || state_q == S_WSQ) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == S_IDLE) begin
        wheel_q <= '0;
      end else if (state_q == S_FIN) begin
        wheel_q <= wheel_q + 1'b1;
        if (upd_q) begin
          angle_q[wheel_q] <= new_ang[ANG_W-1:0];
        end
      end
      if (sqrt_start) begin
        cdone_q <= 1'b0;
        sdone_q <= 1'b0;
      end else begin
        if (cd_res.done) cdone_q <= 1'b1;
        if (sq_res.done) sdone_q <= 1'b1;
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_q <= 1'b0;
      end
      // Register writes
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_EFFORT_THR:  thr_q   <= cfg_wdata_i[THR_W-1:0];
          REG_SPEED_SCALE: scale_q <= cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    if (state_q == S_IDLE && in_ch.valid) begin
      vx_q <= in_ch.vel_x;
      vy_q <= in_ch.vel_y;
      vw_q <= in_ch.vel_turn;
    end
    if (state_q == S_PRE) begin
      case (cnt_q)
        3'd1:    p_q   <= p_rnd[30:15];
        3'd2:    eff_q <= prod_q[31:0];
        3'd3,
        3'd4:    eff_q <= eff_q + prod_q[31:0];
        3'd5:    upd_q <= eff_q > {2'b0, prod_q[29:0]};
        default: ;
      endcase
    end
    if (state_q == S_WSQ && cnt_q == 3'd1) begin
      sum_q <= {1'b0, prod_q[31:0]};
    end
    if (state_q == S_SCL) begin
      scl_q <= {16'b0, sq_res.root} * {25'b0, scale_q};
    end
    if (state_q == S_FIN) begin
      speed_q[wheel_q] <= spd_sat;
      turn_q[wheel_q]  <= upd_q ? diff[TURN_W-1:0] : '0;
    end
    if (out_load) begin
      for (int i = 0; i < 4; i++) begin
        oturn_q[i]  <= turn_q[i];
        ospeed_q[i] <= speed_q[i];
      end
    end
  end

  assign in_ch.ready              = (state_q == S_IDLE);
  assign out_ch.valid             = ovalid_q;
  assign out_ch.turn_front_left   = oturn_q[0];
  assign out_ch.turn_front_right  = oturn_q[1];
  assign out_ch.turn_back_left    = oturn_q[2];
  assign out_ch.turn_back_right   = oturn_q[3];
  // Speed slots follow the kinematic pairing: slot i used y sign of the partner wheel
  assign out_ch.speed_front_left  = ospeed_q[0];
  assign out_ch.speed_front_right = ospeed_q[1];
  assign out_ch.speed_back_left   = ospeed_q[2];
  assign out_ch.speed_back_right  = ospeed_q[3];

  // Checks
  `SWK_ASSERT_NEXT(a_accept_pre, in_ch.valid && in_ch.ready, state_q == S_PRE)
  `SWK_ASSERT_IMPL(a_sqrt_done_run, sq_res.done, state_q == S_RUN)
  `SWK_ASSERT_IMPL(a_cordic_only_upd, cd_res.done, upd_q && state_q == S_RUN)
  `SWK_ASSERT_NEXT(a_hold_angles, state_q == S_FIN && !upd_q, $stable(angle_q[0]) && $stable(angle_q[1]) && $stable(angle_q[2]) && $stable(angle_q[3]))

endmodule
